// File: hw/rtl/pspd_pkg.sv
// ----------------------------------------------------------------------------
// pspd_pkg
// Shared types and constants for the Proth small-prime divisibility block.
// ----------------------------------------------------------------------------
package pspd_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned EXP_W  = 32;
  localparam int unsigned BIT_W  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KMOD,
    ST_KWAIT,
    ST_KTEST,
    ST_P1_TEST,
    ST_P1_MWAIT,
    ST_P1_SWAIT,
    ST_TGT_WAIT,
    ST_P2_TEST,
    ST_P2_MWAIT,
    ST_P2_SWAIT,
    ST_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_KMOD,
    OP_KRED,
    OP_MUL,
    OP_MUL_DONE,
    OP_SQR,
    OP_SQR_DONE,
    OP_TGT,
    OP_P2_INIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic mm_done;   // modular product unit finished
    logic p_even;
    logic k_zero;
    logic e_zero;    // exponent shift register exhausted
    logic e_lsb;
    logic divides;
  } status_t;

endpackage

// File: hw/rtl/pspd_mulmod.sv
// ----------------------------------------------------------------------------
// pspd_mulmod
// Bit-serial modular product (a*b) mod m, one multiplier bit per cycle, MSB
// first; also used for k mod p by treating k as b with a = 1.
// ----------------------------------------------------------------------------
module pspd_mulmod
  import pspd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] m,
  output logic              done,
  output logic [WORD_W-1:0] prod
);

  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [BIT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W-1:0] dbl, gap1, gap2;

  always_comb begin
    gap1 = m - acc_r;
    dbl  = (acc_r >= gap1) ? acc_r - gap1 : acc_r + acc_r;
    gap2 = m - a_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[WORD_W-1])
        acc_nxt = (dbl >= gap2) ? dbl - gap2 : dbl + a_r;
      else
        acc_nxt = dbl;
      b_nxt   = {b_r[WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BIT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: hw/rtl/pspd_datapath.sv
// ----------------------------------------------------------------------------
// pspd_datapath
// Operand registers, the exponent shifter and the shared modular product unit.
// ----------------------------------------------------------------------------
module pspd_datapath
  import pspd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [WORD_W-1:0] in_multiplier,
  input  logic [EXP_W-1:0]  in_exponent,
  input  logic [WORD_W-1:0] in_divisor,
  output status_t           sts
);

  logic [WORD_W-1:0] k_r, k_nxt, p_r, p_nxt, acc_r, acc_nxt, sq_r, sq_nxt;
  logic [WORD_W-1:0] tgt_r, tgt_nxt, e_r, e_nxt;
  logic [EXP_W-1:0]  n_r, n_nxt;
  logic              go;
  logic [WORD_W-1:0] ma, mb, prod;
  logic              mdone;

  pspd_mulmod u_mm (
    .clk  (clk), .rst_n(rst_n), .go(go), .a(ma), .b(mb), .m(p_r),
    .done (mdone), .prod(prod)
  );

  always_comb begin
    k_nxt = k_r; p_nxt = p_r; acc_nxt = acc_r; sq_nxt = sq_r;
    tgt_nxt = tgt_r; e_nxt = e_r; n_nxt = n_r;
    go = 1'b0; ma = '0; mb = '0;
    case (cmd.op)
      OP_LOAD: begin
        k_nxt = in_multiplier; p_nxt = in_divisor; n_nxt = in_exponent;
      end
      OP_KMOD: begin
        go = 1'b1; ma = WORD_W'(1); mb = k_r;
      end
      OP_KRED: begin
        sq_nxt = prod; acc_nxt = WORD_W'(1);
        e_nxt = p_r - WORD_W'(2);
      end
      OP_MUL: begin
        go = 1'b1; ma = acc_r; mb = sq_r;
      end
      // take acc*sq and launch sq*sq in the same cycle
      OP_MUL_DONE: begin
        acc_nxt = prod;
        go = 1'b1; ma = sq_r; mb = sq_r;
      end
      OP_SQR: begin
        go = 1'b1; ma = sq_r; mb = sq_r;
      end
      OP_SQR_DONE: begin
        sq_nxt = prod; e_nxt = e_r >> 1;
      end
      OP_TGT: begin
        go = 1'b1; ma = p_r - WORD_W'(1); mb = acc_r;
      end
      OP_P2_INIT: begin
        tgt_nxt = prod; acc_nxt = WORD_W'(1); sq_nxt = WORD_W'(2);
        e_nxt = {{(WORD_W-EXP_W){1'b0}}, n_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt; p_r <= p_nxt; acc_r <= acc_nxt; sq_r <= sq_nxt;
    tgt_r <= tgt_nxt; e_r <= e_nxt; n_r <= n_nxt;
  end

  assign sts.mm_done = mdone;
  assign sts.p_even  = ~p_r[0];
  assign sts.k_zero  = (sq_r == '0);
  assign sts.e_zero  = (e_r == '0);
  assign sts.e_lsb   = e_r[0];
  assign sts.divides = (acc_r == tgt_r);

endmodule

// File: hw/rtl/pspd_ctrl.sv
// ----------------------------------------------------------------------------
// pspd_ctrl
// Sequencer for the two modular powers and the final compare.
// ----------------------------------------------------------------------------
module pspd_ctrl
  import pspd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid,
  output logic    out_divides
);

  state_t st_r, st_nxt;
  logic   res_r, res_nxt;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (start) st_nxt = ST_KMOD;
      ST_KMOD:     st_nxt = sts.p_even ? ST_DONE : ST_KWAIT;
      ST_KWAIT:    if (sts.mm_done) st_nxt = ST_KTEST;
      ST_KTEST:    st_nxt = sts.k_zero ? ST_DONE : ST_P1_TEST;
      ST_P1_TEST:  st_nxt = sts.e_zero ? ST_TGT_WAIT :
                            (sts.e_lsb ? ST_P1_MWAIT : ST_P1_SWAIT);
      ST_P1_MWAIT: if (sts.mm_done) st_nxt = ST_P1_SWAIT;
      ST_P1_SWAIT: if (sts.mm_done) st_nxt = ST_P1_TEST;
      ST_TGT_WAIT: if (sts.mm_done) st_nxt = ST_P2_TEST;
      ST_P2_TEST:  st_nxt = sts.e_zero ? ST_DONE :
                            (sts.e_lsb ? ST_P2_MWAIT : ST_P2_SWAIT);
      ST_P2_MWAIT: if (sts.mm_done) st_nxt = ST_P2_SWAIT;
      ST_P2_SWAIT: if (sts.mm_done) st_nxt = ST_P2_TEST;
      ST_DONE:     st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (st_r)
      ST_IDLE:     if (start) cmd.op = OP_LOAD;
      ST_KMOD:     if (!sts.p_even) cmd.op = OP_KMOD;
      ST_KWAIT:    if (sts.mm_done) cmd.op = OP_KRED;
      ST_P1_TEST: begin
        if (sts.e_zero)     cmd.op = OP_TGT;
        else if (sts.e_lsb) cmd.op = OP_MUL;
        else                cmd.op = OP_SQR;
      end
      ST_P2_TEST: begin
        if (!sts.e_zero)
          cmd.op = sts.e_lsb ? OP_MUL : OP_SQR;
      end
      ST_P1_MWAIT, ST_P2_MWAIT: if (sts.mm_done) cmd.op = OP_MUL_DONE;
      ST_P1_SWAIT, ST_P2_SWAIT: if (sts.mm_done) cmd.op = OP_SQR_DONE;
      ST_TGT_WAIT: if (sts.mm_done) cmd.op = OP_P2_INIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    if (st_r == ST_IDLE && start) res_nxt = 1'b0;
    if (st_r == ST_P2_TEST && sts.e_zero) res_nxt = sts.divides;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; res_r <= 1'b0;
    end else begin
      st_r <= st_nxt; res_r <= res_nxt;
    end
  end

  assign busy        = (st_r != ST_IDLE);
  assign out_valid   = (st_r == ST_DONE);
  assign out_divides = res_r;

endmodule

// File: hw/rtl/proth_small_prime_divisibility.sv
// ----------------------------------------------------------------------------
// proth_small_prime_divisibility
// Reports whether p passes the Fermat divisibility test for k*2^n+1.
// ----------------------------------------------------------------------------
// One transaction at a time: after start is taken, busy stays high until the
// one-cycle out_valid strobe, and a new start is taken the cycle after it.
// Every modular product runs in a shared bit-serial unit. Each exponent bit
// costs a squaring, plus a multiplication when the bit is set; the exponents
// are p-2 and n. Reducing k mod p and forming the target take one product each;
// an even divisor skips every modular product. The result cannot be stalled.
module proth_small_prime_divisibility
  import pspd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] in_multiplier,
  input  logic [EXP_W-1:0]  in_exponent,
  input  logic [WORD_W-1:0] in_divisor,
  output logic              out_valid,
  output logic              out_divides
);

  cmd_t    cmd;
  status_t sts;

  pspd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .out_valid(out_valid), .out_divides(out_divides)
  );

  pspd_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_multiplier(in_multiplier),
    .in_exponent(in_exponent), .in_divisor(in_divisor), .sts(sts)
  );

endmodule
